// ----- src/assert_macros.svh -----
// Assertion macros shared by the bounded set store RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define BSS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bss_pkg.sv -----
// Package for the bounded set store: sizes, command codes, states and the result struct.
// Depends on nothing; used by bss_engine and bounded_set_store.
`default_nettype none

package bss_pkg;

  localparam int CAPACITY   = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               success;
    logic               full_reject;
    logic [COUNT_W-1:0] member_total;
    logic               is_empty;
  } res_t;

endpackage

`default_nettype wire

// ----- src/bss_engine.sv -----
// Sequencer, entry store and shared compare unit of the bounded set store.
// Depends on bss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bss_engine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      command,
  input  wire logic [bss_pkg::ITEM_WIDTH-1:0]  item_value,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output bss_pkg::res_t                        res
);
  import bss_pkg::*;

  logic [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic [ITEM_WIDTH-1:0] rdata;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ITEM_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]      raddr;

  state_t                state, state_next;
  cmd_t                  cmd, cmd_next;
  logic [ITEM_WIDTH-1:0] value, value_next;
  logic [COUNT_W-1:0]    rd_idx, rd_idx_next;
  logic                  pend, pend_next;
  logic [IDX_W-1:0]      slot, slot_next;
  logic [COUNT_W-1:0]    count, count_next;
  logic                  ok, ok_next;
  logic                  full, full_next;
  logic                  match;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    value  <= value_next;
    rd_idx <= rd_idx_next;
    slot   <= slot_next;
    ok     <= ok_next;
    full   <= full_next;
  end

  assign match = pend && (rdata == value);

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    value_next  = value;
    rd_idx_next = rd_idx;
    pend_next   = pend;
    slot_next   = slot;
    count_next  = count;
    ok_next     = ok;
    full_next   = full;
    we          = 1'b0;
    waddr       = slot;
    wdata       = value;
    raddr       = rd_idx[IDX_W-1:0];
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next    = cmd_t'(command);
          value_next  = item_value[ITEM_WIDTH-1:0];
          rd_idx_next = '0;
          pend_next   = 1'b0;
          ok_next     = 1'b0;
          full_next   = 1'b0;
          if (cmd_t'(command) == CMD_CLEAR) begin
            count_next = '0;
            ok_next    = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match || (rd_idx == count)) begin
          slot_next  = IDX_W'(rd_idx - COUNT_W'(1));
          pend_next  = 1'b0;
          state_next = ST_DONE;
          case (cmd)
            CMD_ADD: begin
              if (!match) begin
                if (count >= COUNT_W'(CAPACITY)) begin
                  full_next = 1'b1;
                end else begin
                  we         = 1'b1;
                  waddr      = count[IDX_W-1:0];
                  count_next = count + COUNT_W'(1);
                  ok_next    = 1'b1;
                end
              end
            end
            CMD_REMOVE: begin
              if (match) begin
                ok_next    = 1'b1;
                state_next = ST_MOVE_RD;
              end
            end
            CMD_CONTAINS: begin
              ok_next = match;
            end
            default: begin
              ok_next = 1'b1;
            end
          endcase
        end else begin
          rd_idx_next = rd_idx + COUNT_W'(1);
          pend_next   = 1'b1;
        end
      end
      ST_MOVE_RD: begin
        raddr      = IDX_W'(count - COUNT_W'(1));
        state_next = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        we         = 1'b1;
        waddr      = slot;
        wdata      = rdata;
        count_next = count - COUNT_W'(1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.success      = ok;
  assign res.full_reject  = full;
  assign res.member_total = count;
  assign res.is_empty     = (count == '0);

  `BSS_ASSERT(a_count_bound, count <= COUNT_W'(CAPACITY), "Member count exceeds capacity.")
  `BSS_ASSERT(a_scan_bound, (state != ST_SCAN) || (rd_idx <= count), "Scan ran past the members.")
  `BSS_ASSERT(a_flags_excl, !(res_valid && res.success && res.full_reject), "Success with full reject.")
  `BSS_ASSERT_NEXT(a_remove_dec, state == ST_MOVE_WR, count == $past(count) - COUNT_W'(1), "Remove did not shrink the set.")

endmodule

`default_nettype wire

// ----- src/bounded_set_store.sv -----
// Bounded set store: an unordered set of distinct values with add, remove, contains, clear.
// Usage: commands enter on the in_valid/in_ready channel as one transaction each
// (command and item_value). Every command gives exactly one result transaction on
// out_valid/out_ready with success, full_reject, member_total and is_empty.
// Add, remove and contains scan the occupied entries one per cycle through a single
// read port and one comparator; clear goes straight to its result without a scan.
// A successful remove then reads the last entry and writes it into the freed slot.
// in_ready is low while a command is in work, so commands do not overlap.
// The result sits in an output register, so the next command is accepted while
// a finished result still waits to be taken.
// When the receiver stalls, the result holds and the engine waits with its own
// finished result until the output register frees.
// Reset empties the set at once; the stored entries need no clearing pass.
// Depends on bss_pkg and bss_engine.
`default_nettype none

module bounded_set_store (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      command,
  input  wire logic [31:0]                     item_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 success,
  output logic                                 full_reject,
  output logic [bss_pkg::COUNT_W-1:0]          member_total,
  output logic                                 is_empty
);
  import bss_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  bss_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .item_value (item_value[ITEM_WIDTH-1:0]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      success      <= res.success;
      full_reject  <= res.full_reject;
      member_total <= res.member_total;
      is_empty     <= res.is_empty;
    end
  end

endmodule

`default_nettype wire
